// ===== src/kbc_pkg.sv =====
// Shared types and constants for the k-nearest-neighbor classifier.
`timescale 1ns / 1ps
`default_nettype none
package kbc_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned DIST_W  = 37;
  localparam int unsigned K_W     = 7;
  localparam int unsigned SQ_W    = 34;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [K_W-1:0]    K_RESET  = 7'd3;

  localparam logic signed [1:0] LABEL_NONE = -2'sd1;
  localparam logic signed [1:0] LABEL_ZERO = 2'sd0;
  localparam logic signed [1:0] LABEL_ONE  = 2'sd1;

  typedef enum logic [1:0] {
    FUNC_TRAIN = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] coord_value;
    logic                      train_label;
    logic                      last_coord;
  } in_t;

  typedef struct packed {
    logic signed [1:0] predicted_label;
    logic [K_W-1:0]    winning_votes;
  } out_t;

  typedef struct packed {
    logic train_wr;
    logic train_last;
    logic acc_en;
    logic acc_clr;
    logic rank_start;
    logic rank_step;
    logic vote_load;
    logic vote_step;
  } ctrl_t;

endpackage
`default_nettype wire

// ===== src/kbc_cell.sv =====
// One cell: a stored point, its distance accumulator and its rank.
`timescale 1ns / 1ps
`default_nettype none
module kbc_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned DIMS       = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire kbc_pkg::ctrl_t                      ctrl_i,
  input  wire logic [$clog2(MAX_POINTS+1)-1:0]     stored_i,
  input  wire logic [$clog2(DIMS+1)-1:0]           pos_i,
  input  wire logic signed [kbc_pkg::COORD_W-1:0]  coord_i,
  input  wire logic                                label_i,
  input  wire logic [kbc_pkg::K_W-1:0]             k_i,
  input  wire logic [kbc_pkg::DIST_W-1:0]          circ_dist_i,
  input  wire logic [((MAX_POINTS>1)?$clog2(MAX_POINTS):1)-1:0] circ_idx_i,
  input  wire logic                                circ_vld_i,
  output logic [kbc_pkg::DIST_W-1:0]               circ_dist_o,
  output logic [((MAX_POINTS>1)?$clog2(MAX_POINTS):1)-1:0] circ_idx_o,
  output logic                                     circ_vld_o,
  input  wire logic                                vote_vld_i,
  input  wire logic                                vote_lbl_i,
  output logic                                     vote_vld_o,
  output logic                                     vote_lbl_o
);

  localparam int unsigned SW  = $clog2(MAX_POINTS+1);
  localparam int unsigned PW  = $clog2(DIMS+1);
  localparam int unsigned AW  = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int unsigned IW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned RW  = $clog2(MAX_POINTS+1);
  localparam int unsigned CW  = (RW > kbc_pkg::K_W) ? RW : kbc_pkg::K_W;
  localparam int unsigned DW  = kbc_pkg::DIST_W;

  logic signed [kbc_pkg::COORD_W-1:0] tc_q [DIMS];
  logic                               lbl_q;
  logic [DW-1:0]                      acc_q, acc_d;
  logic [DW-1:0]                      circ_dist_q;
  logic [IW-1:0]                      circ_idx_q;
  logic                               circ_vld_q;
  logic [RW-1:0]                      rank_q;
  logic                               vote_vld_q, vote_lbl_q;

  logic                               valid, mine, pos_ok, acc_upd, closer;
  logic signed [kbc_pkg::COORD_W:0]   diff;
  logic signed [2*kbc_pkg::COORD_W+1:0] prod;
  logic [DW:0]                        sum;

  assign valid  = stored_i > SW'(IDX);
  assign mine   = stored_i == SW'(IDX);
  assign pos_ok = pos_i < PW'(DIMS);

  assign diff = {coord_i[kbc_pkg::COORD_W-1], coord_i}
              - {tc_q[pos_i[AW-1:0]][kbc_pkg::COORD_W-1], tc_q[pos_i[AW-1:0]]};
  assign prod = diff * diff;
  assign sum  = {1'b0, acc_q} + (DW+1)'(prod[kbc_pkg::SQ_W-1:0]);
  assign acc_d = sum[DW] ? kbc_pkg::DIST_MAX : sum[DW-1:0];
  assign acc_upd = ctrl_i.acc_en && valid && pos_ok;

  assign closer = circ_vld_i && valid &&
                  ((circ_dist_i < acc_q) ||
                   ((circ_dist_i == acc_q) && (circ_idx_i < IW'(IDX))));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.train_wr && mine && pos_ok) begin
      tc_q[pos_i[AW-1:0]] <= coord_i;
    end
    if (ctrl_i.train_last && mine) begin
      lbl_q <= label_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      circ_dist_q <= '0;
      circ_idx_q  <= '0;
      circ_vld_q  <= 1'b0;
      rank_q      <= '0;
      vote_vld_q  <= 1'b0;
      vote_lbl_q  <= 1'b0;
    end else begin
      if (ctrl_i.acc_clr) begin
        acc_q <= '0;
      end else if (acc_upd) begin
        acc_q <= acc_d;
      end
      if (ctrl_i.rank_start) begin
        circ_dist_q <= acc_upd ? acc_d : acc_q;
        circ_idx_q  <= IW'(IDX);
        circ_vld_q  <= valid;
        rank_q      <= '0;
      end else if (ctrl_i.rank_step) begin
        circ_dist_q <= circ_dist_i;
        circ_idx_q  <= circ_idx_i;
        circ_vld_q  <= circ_vld_i;
        if (closer) begin
          rank_q <= rank_q + RW'(1);
        end
      end
      if (ctrl_i.vote_load) begin
        vote_vld_q <= valid && (CW'(rank_q) < CW'(k_i));
        vote_lbl_q <= lbl_q;
      end else if (ctrl_i.vote_step) begin
        vote_vld_q <= vote_vld_i;
        vote_lbl_q <= vote_lbl_i;
      end
    end
  end

  assign circ_dist_o = circ_dist_q;
  assign circ_idx_o  = circ_idx_q;
  assign circ_vld_o  = circ_vld_q;
  assign vote_vld_o  = vote_vld_q;
  assign vote_lbl_o  = vote_lbl_q;

endmodule
`default_nettype wire

// ===== src/knn_binary_classifier.sv =====
// Top level: k-nearest-neighbor binary classifier over a ring of point cells.
// Training coordinates, clears and all query coordinates but the last are
// accepted back to back. The last coordinate of a query keeps the block busy:
// every cell folds the coordinate into its distance in the accept cycle, the
// distances then travel once around the ring of MAX_POINTS cells so that each
// cell counts how many stored points are nearer (ties to the lower index),
// then the votes shift out of the chain end into the vote counters. The result
// sits in an output register; items that produce no result are still taken
// while it waits.
`timescale 1ns / 1ps
`default_nettype none
module knn_binary_classifier #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned DIMS       = 8,
  parameter int unsigned MAX_K      = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire kbc_pkg::in_t              in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output kbc_pkg::out_t                  out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [kbc_pkg::K_W-1:0]   cfg_data_i
);

  localparam int unsigned SW = $clog2(MAX_POINTS+1);
  localparam int unsigned PW = $clog2(DIMS+1);
  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned DW = kbc_pkg::DIST_W;
  localparam int unsigned KW = kbc_pkg::K_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RANK, S_VLOAD, S_VOTE, S_DONE
  } state_e;

  state_e             state_q;
  logic [IW-1:0]      cnt_q;
  logic [SW-1:0]      stored_q;
  logic [PW-1:0]      pos_q;
  logic [KW-1:0]      k_q, k_eff;
  logic [KW-1:0]      v1_q, v0_q;
  logic               out_vld_q;
  kbc_pkg::out_t      out_q;
  kbc_pkg::ctrl_t     ctrl;

  logic               accept, is_train, is_query, is_clear, cnt_end;

  logic [DW-1:0]      circ_dist [MAX_POINTS];
  logic [IW-1:0]      circ_idx  [MAX_POINTS];
  logic               circ_vld  [MAX_POINTS];
  logic               vote_vld  [MAX_POINTS];
  logic               vote_lbl  [MAX_POINTS];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign is_train   = accept && (in_data_i.func == kbc_pkg::FUNC_TRAIN);
  assign is_query   = accept && (in_data_i.func == kbc_pkg::FUNC_QUERY);
  assign is_clear   = accept && (in_data_i.func == kbc_pkg::FUNC_CLEAR);
  assign cnt_end    = (cnt_q == IW'(MAX_POINTS-1));

  always_comb begin
    priority if (k_q == '0) begin
      k_eff = KW'(1);
    end else if (k_q > KW'(MAX_K)) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = k_q;
    end
  end

  always_comb begin
    ctrl            = '0;
    ctrl.train_wr   = is_train && (stored_q < SW'(MAX_POINTS));
    ctrl.train_last = ctrl.train_wr && in_data_i.last_coord;
    ctrl.acc_en     = is_query;
    ctrl.acc_clr    = is_clear || (state_q == S_VLOAD);
    ctrl.rank_start = is_query && in_data_i.last_coord;
    ctrl.rank_step  = (state_q == S_RANK);
    ctrl.vote_load  = (state_q == S_VLOAD);
    ctrl.vote_step  = (state_q == S_VOTE);
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int unsigned PREV = (i == 0) ? MAX_POINTS - 1 : i - 1;
    logic vin_vld, vin_lbl;
    if (i == 0) begin : g_head
      assign vin_vld = 1'b0;
      assign vin_lbl = 1'b0;
    end else begin : g_link
      assign vin_vld = vote_vld[i-1];
      assign vin_lbl = vote_lbl[i-1];
    end
    kbc_cell #(
      .IDX(i), .MAX_POINTS(MAX_POINTS), .DIMS(DIMS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .stored_i    (stored_q),
      .pos_i       (pos_q),
      .coord_i     (in_data_i.coord_value),
      .label_i     (in_data_i.train_label),
      .k_i         (k_eff),
      .circ_dist_i (circ_dist[PREV]),
      .circ_idx_i  (circ_idx[PREV]),
      .circ_vld_i  (circ_vld[PREV]),
      .circ_dist_o (circ_dist[i]),
      .circ_idx_o  (circ_idx[i]),
      .circ_vld_o  (circ_vld[i]),
      .vote_vld_i  (vin_vld),
      .vote_lbl_i  (vin_lbl),
      .vote_vld_o  (vote_vld[i]),
      .vote_lbl_o  (vote_lbl[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= kbc_pkg::K_RESET;
    end else if (cfg_we_i) begin
      k_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= '0;
      pos_q    <= '0;
    end else begin
      if (is_clear) begin
        stored_q <= '0;
        pos_q    <= '0;
      end else if (is_train || is_query) begin
        if (ctrl.train_last) begin
          stored_q <= stored_q + SW'(1);
        end
        if (in_data_i.last_coord) begin
          pos_q <= '0;
        end else if (pos_q < PW'(DIMS)) begin
          pos_q <= pos_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      v1_q      <= '0;
      v0_q      <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      if (out_ready_i && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (ctrl.rank_start) begin
            state_q <= S_RANK;
            cnt_q   <= '0;
          end
        end
        S_RANK: begin
          cnt_q <= cnt_q + IW'(1);
          if (cnt_end) begin
            state_q <= S_VLOAD;
          end
        end
        S_VLOAD: begin
          cnt_q   <= '0;
          v1_q    <= '0;
          v0_q    <= '0;
          state_q <= S_VOTE;
        end
        S_VOTE: begin
          cnt_q <= cnt_q + IW'(1);
          if (vote_vld[MAX_POINTS-1]) begin
            if (vote_lbl[MAX_POINTS-1]) begin
              v1_q <= v1_q + KW'(1);
            end else begin
              v0_q <= v0_q + KW'(1);
            end
          end
          if (cnt_end) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || out_ready_i) begin
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
            if (stored_q == '0) begin
              out_q.predicted_label <= kbc_pkg::LABEL_NONE;
              out_q.winning_votes   <= '0;
            end else if (v1_q > v0_q) begin
              out_q.predicted_label <= kbc_pkg::LABEL_ONE;
              out_q.winning_votes   <= v1_q;
            end else begin
              out_q.predicted_label <= kbc_pkg::LABEL_ZERO;
              out_q.winning_votes   <= v0_q;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== src/kbc_checker.sv =====
// Port-level assertions for the classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kbc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire kbc_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire kbc_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.func == kbc_pkg::FUNC_QUERY) &&
    in_data_i.last_coord |=> !in_ready_o)
    else $error("input taken during classification");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.predicted_label == kbc_pkg::LABEL_NONE)
    |-> (out_data_o.winning_votes == '0))
    else $error("votes reported with no stored points");

  a_votes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.predicted_label != kbc_pkg::LABEL_NONE)
    |-> (out_data_o.winning_votes != '0))
    else $error("winning label without votes");

endmodule

bind knn_binary_classifier kbc_checker u_kbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
